// ===== hw/rtl/efl_pkg.sv =====
package efl_pkg;

   // Fixed layout constants of the heap
   localparam int unsigned ADDR_W      = 17;
   localparam int unsigned WORD_W      = 32;
   localparam logic [16:0] MIN_BLOCK   = 17'd24;
   localparam logic [16:0] TAG_BYTES   = 17'd8;
   localparam logic [16:0] FIRST_PAYLD = 17'd32;
   localparam logic [16:0] CHUNK_RESET = 17'd4096;
   localparam logic [16:0] PRO_HDR     = 17'd4;
   localparam logic [16:0] PRO_FTR     = 17'd24;
   localparam logic [16:0] EPI_HDR     = 17'd28;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_IGNORE = 2'd1;
   localparam logic [1:0] ST_OOM    = 2'd2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Datapath operations issued by the controller, one per cycle
   typedef enum logic [5:0] {
      OP_NONE,
      OP_LATCH,
      OP_INIT0,
      OP_INIT1,
      OP_INIT2,
      OP_SET_IGN,
      OP_SET_OOM,
      OP_ASIZE,
      OP_GROW_SETUP,
      OP_FIT_RD,
      OP_FIT_NEXT_RD,
      OP_FIT_NEXT,
      OP_FIT_TAKE,
      OP_CARVE_RD,
      OP_CARVE_UL,
      OP_CARVE_HDR_SPLIT,
      OP_CARVE_FTR_SPLIT,
      OP_CARVE_REM_HDR,
      OP_CARVE_REM_FTR,
      OP_CARVE_HDR_WHOLE,
      OP_CARVE_FTR_WHOLE,
      OP_GROW_FAIL,
      OP_GROW_HDR,
      OP_GROW_FTR,
      OP_GROW_EPI,
      OP_M_HDR_RD,
      OP_M_PREV_RD,
      OP_M_NEXT_RD,
      OP_M_NEXT_MERGE,
      OP_M_PREV_HDR_RD,
      OP_M_PREV_MERGE,
      OP_M_HDR_WR,
      OP_M_FTR_WR,
      OP_PUSH_NEXT,
      OP_PUSH_BACK,
      OP_PUSH_HEAD,
      OP_UL_PREV_RD,
      OP_UL_NEXT_RD,
      OP_UL_FIX_PREV,
      OP_UL_FIX_HEAD,
      OP_UL_FIX_NEXT,
      OP_W_START,
      OP_W_RD,
      OP_W_STEP,
      OP_F_HDR,
      OP_F_FTR,
      OP_OUT
   } op_type;

   typedef enum logic [5:0] {
      S_INIT0,
      S_INIT1,
      S_INIT2,
      S_IDLE,
      S_DISPATCH,
      S_A_FIT,
      S_A_FIT_CHK,
      S_A_FIT_NEXT,
      S_A_GROWN,
      S_C_RD,
      S_C_UL,
      S_C_DECIDE,
      S_C_FTR_SPLIT,
      S_C_REM_HDR,
      S_C_REM_FTR,
      S_C_FTR_WHOLE,
      S_G_CHK,
      S_G_FTR,
      S_G_EPI,
      S_M_HDR,
      S_M_PREV,
      S_M_NEXT,
      S_M_NCHK,
      S_M_PCHK,
      S_M_PMERGE,
      S_M_HDR_WR,
      S_M_FTR_WR,
      S_P_NEXT,
      S_P_BACK,
      S_P_HEAD,
      S_U_PREV,
      S_U_NEXT,
      S_U_FIX,
      S_U_FIXN,
      S_F_START,
      S_F_WALK,
      S_F_CHK,
      S_F_FTR,
      S_RESP
   } state_type;

   // Status flags from datapath to controller
   typedef struct packed {
      logic cmd_free;
      logic req_zero;
      logic addr_zero;
      logic fit_null;
      logic fit_ok;
      logic split;
      logic grow_fits;
      logic gfail;
      logic next_free;
      logic prev_free;
      logic fhead_nz;
      logic lp_nz;
      logic ln_nz;
      logic walk_end;
      logic walk_size0;
      logic walk_hit;
      logic walk_alloc;
      logic walk_past;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/efl_intf.sv =====
// Request channel
interface efl_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] req_size;
   logic [15:0] block_addr;

   modport source (output valid, output cmd, output req_size, output block_addr,
                   input ready);
   modport sink   (input valid, input cmd, input req_size, input block_addr,
                   output ready);
endinterface

// Response channel
interface efl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] payload_addr;

   modport source (output valid, output status, output payload_addr, input ready);
   modport sink   (input valid, input status, input payload_addr, output ready);
endinterface

// ===== hw/rtl/explicit_free_list_heap_allocator.sv =====
// Allocate: first fit over the explicit free list, one node at a time; the block is
//   split when the remainder is large enough, and the heap grows when no node fits;
//   grown and remainder blocks are merged with free neighbors. One memory port.
// Free: walks the blocks from the heap start to the given address, then a merge.
// One request at a time; the next is taken once the result is registered.
// Reset: synchronous; start-up then writes the prologue, epilogue and first chunk.
module explicit_free_list_heap_allocator
   import efl_pkg::*;
#(
   parameter int HEAP_BYTES = 65536
) (
   input  logic          clock,
   input  logic          reset,
   efl_req_if.sink       req_ch,
   efl_rsp_if.source     rsp_ch,
   input  logic          csr_wr_en,
   input  logic [16:0]   csr_wr_data
);
   op_type        op;
   dp_status_type dp_status;

   efl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (dp_status),
      .op        (op)
   );

   efl_datapath #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .status           (dp_status),
      .req_cmd          (req_ch.cmd),
      .req_size         (req_ch.req_size),
      .req_block_addr   (req_ch.block_addr),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_status       (rsp_ch.status),
      .rsp_payload_addr (rsp_ch.payload_addr)
   );
endmodule

// ===== hw/rtl/efl_ram.sv =====
module efl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // single port, registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end
endmodule

// ===== hw/rtl/efl_datapath.sv =====
module efl_datapath
   import efl_pkg::*;
#(
   parameter int HEAP_BYTES = 65536
) (
   input  logic          clock,
   input  logic          reset,
   input  op_type        op,
   output dp_status_type status,
   input  logic          req_cmd,
   input  logic [15:0]   req_size,
   input  logic [15:0]   req_block_addr,
   input  logic          csr_wr_en,
   input  logic [16:0]   csr_wr_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_status,
   output logic [15:0]   rsp_payload_addr
);
   localparam int MEM_LIMIT = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
   localparam int MEM_WORDS = MEM_LIMIT / 4;
   localparam int IW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   logic        cmd_ff, cmd_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] baddr_ff, baddr_in;
   logic [1:0]  st_ff, st_in;
   logic [15:0] grant_ff, grant_in;
   logic [16:0] asize_ff, asize_in;
   logic [16:0] gbytes_ff, gbytes_in;
   logic [15:0] fb_ff, fb_in;
   logic [16:0] bp_ff, bp_in;
   logic [16:0] sz_ff, sz_in;
   logic [16:0] ub_ff, ub_in;
   logic [15:0] lp_ff, lp_in;
   logic [15:0] ln_ff, ln_in;
   logic [16:0] pws_ff, pws_in;
   logic        pwf_ff, pwf_in;
   logic [16:0] csize_ff, csize_in;
   logic [16:0] p_ff, p_in;
   logic [15:0] fhead_ff, fhead_in;
   logic [16:0] hend_ff, hend_in;
   logic        gfail_ff, gfail_in;
   logic [16:0] chunk_ff, chunk_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;

   logic              mem_en, mem_we;
   logic [16:0]       mem_addr;
   logic [WORD_W-1:0] mem_wdata, rd;
   logic              mem_in_range;

   logic [16:0] rdsize, round8, asize_calc, rem, pprev;
   logic [14:0] gw;
   logic [15:0] gw_even;
   logic [17:0] gsz_raw, gsz;
   logic [18:0] grow_top;

   efl_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_heap (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we && mem_in_range),
      .addr  (mem_addr[IW+1:2]),
      .wdata (mem_wdata),
      .rdata (rd)
   );

   // derived values
   assign mem_in_range = ({2'b00, mem_addr[16:2]} < 17'(MEM_WORDS));
   assign rdsize     = {rd[16:3], 3'b000};
   assign round8     = ({1'b0, size_ff} + 17'd7) & ~17'd7;
   assign asize_calc = ((round8 + TAG_BYTES) < MIN_BLOCK) ? MIN_BLOCK : (round8 + TAG_BYTES);
   assign rem        = csize_ff - asize_ff;
   assign pprev      = bp_ff - pws_ff;
   assign gw         = gbytes_ff[16:2];
   assign gw_even    = {1'b0, gw} + {15'd0, gw[0]};
   assign gsz_raw    = {gw_even, 2'b00};
   assign gsz        = (gsz_raw < {1'b0, MIN_BLOCK}) ? {1'b0, MIN_BLOCK} : gsz_raw;
   assign grow_top   = {2'b00, hend_ff} + {1'b0, gsz};

   // status to controller
   always_comb begin
      status.cmd_free   = (cmd_ff == CMD_FREE);
      status.req_zero   = (size_ff == 16'd0);
      status.addr_zero  = (baddr_ff == 16'd0);
      status.fit_null   = (fb_ff == 16'd0);
      status.fit_ok     = (rdsize >= asize_ff);
      status.split      = (rem >= MIN_BLOCK);
      status.grow_fits  = (grow_top <= 19'(MEM_LIMIT));
      status.gfail      = gfail_ff;
      status.next_free  = ~rd[0];
      status.prev_free  = ~pwf_ff;
      status.fhead_nz   = (fhead_ff != 16'd0);
      status.lp_nz      = (lp_ff != 16'd0);
      status.ln_nz      = (ln_ff != 16'd0);
      status.walk_end   = (p_ff >= hend_ff);
      status.walk_size0 = (rdsize == 17'd0);
      status.walk_hit   = (p_ff == {1'b0, baddr_ff});
      status.walk_alloc = rd[0];
      status.walk_past  = (p_ff > {1'b0, baddr_ff});
      status.out_free   = ~rsp_valid_ff | rsp_ready;
   end

   // operation decode
   always_comb begin
      cmd_in = cmd_ff;       size_in = size_ff;     baddr_in = baddr_ff;
      st_in = st_ff;         grant_in = grant_ff;   asize_in = asize_ff;
      gbytes_in = gbytes_ff; fb_in = fb_ff;         bp_in = bp_ff;
      sz_in = sz_ff;         ub_in = ub_ff;         lp_in = lp_ff;
      ln_in = ln_ff;         pws_in = pws_ff;       pwf_in = pwf_ff;
      csize_in = csize_ff;   p_in = p_ff;           fhead_in = fhead_ff;
      hend_in = hend_ff;     gfail_in = gfail_ff;   chunk_in = chunk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in = rsp_addr_ff;
      mem_en = 1'b0;
      mem_we = 1'b0;
      mem_addr = '0;
      mem_wdata = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         chunk_in = csr_wr_data;
      end

      case (op)
         OP_LATCH: begin
            cmd_in = req_cmd; size_in = req_size; baddr_in = req_block_addr;
            st_in = ST_DONE; grant_in = 16'd0;
         end
         OP_INIT0: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = PRO_HDR;
            mem_wdata = {15'd0, MIN_BLOCK | 17'd1};
         end
         OP_INIT1: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = PRO_FTR;
            mem_wdata = {15'd0, MIN_BLOCK | 17'd1};
         end
         OP_INIT2: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = EPI_HDR; mem_wdata = 32'd1;
            hend_in = FIRST_PAYLD; fhead_in = 16'd0; gbytes_in = CHUNK_RESET;
         end
         OP_SET_IGN: st_in = ST_IGNORE;
         OP_SET_OOM: st_in = ST_OOM;
         OP_ASIZE: begin
            asize_in = asize_calc;
            fb_in = fhead_ff;
         end
         OP_GROW_SETUP: gbytes_in = (asize_ff > chunk_ff) ? asize_ff : chunk_ff;
         OP_FIT_RD: begin
            mem_en = 1'b1; mem_addr = {1'b0, fb_ff} - 17'd4;
         end
         OP_FIT_NEXT_RD: begin
            mem_en = 1'b1; mem_addr = {1'b0, fb_ff} + 17'd8;
         end
         OP_FIT_NEXT: fb_in = rd[15:0];
         OP_FIT_TAKE: bp_in = {1'b0, fb_ff};
         OP_CARVE_RD: begin
            grant_in = bp_ff[15:0];
            mem_en = 1'b1; mem_addr = bp_ff - 17'd4;
         end
         OP_CARVE_UL: begin
            csize_in = rdsize; ub_in = bp_ff;
         end
         OP_CARVE_HDR_SPLIT: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff - 17'd4;
            mem_wdata = {15'd0, asize_ff | 17'd1};
         end
         OP_CARVE_FTR_SPLIT: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff + asize_ff - TAG_BYTES;
            mem_wdata = {15'd0, asize_ff | 17'd1};
         end
         OP_CARVE_REM_HDR: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff + asize_ff - 17'd4;
            mem_wdata = {15'd0, rem};
         end
         OP_CARVE_REM_FTR: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff + csize_ff - TAG_BYTES;
            mem_wdata = {15'd0, rem};
            bp_in = bp_ff + asize_ff;
         end
         OP_CARVE_HDR_WHOLE: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff - 17'd4;
            mem_wdata = {15'd0, csize_ff | 17'd1};
         end
         OP_CARVE_FTR_WHOLE: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff + csize_ff - TAG_BYTES;
            mem_wdata = {15'd0, csize_ff | 17'd1};
         end
         OP_GROW_FAIL: gfail_in = 1'b1;
         OP_GROW_HDR: begin
            gfail_in = 1'b0; bp_in = hend_ff; sz_in = gsz[16:0];
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = hend_ff - 17'd4;
            mem_wdata = {14'd0, gsz};
         end
         OP_GROW_FTR: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff + sz_ff - TAG_BYTES;
            mem_wdata = {15'd0, sz_ff};
         end
         OP_GROW_EPI: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff + sz_ff - 17'd4;
            mem_wdata = 32'd1;
            hend_in = bp_ff + sz_ff;
         end
         OP_M_HDR_RD: begin
            mem_en = 1'b1; mem_addr = bp_ff - 17'd4;
         end
         OP_M_PREV_RD: begin
            sz_in = rdsize;
            mem_en = 1'b1; mem_addr = bp_ff - TAG_BYTES;
         end
         OP_M_NEXT_RD: begin
            pws_in = rdsize; pwf_in = rd[0];
            mem_en = 1'b1; mem_addr = bp_ff + sz_ff - 17'd4;
         end
         OP_M_NEXT_MERGE: begin
            ub_in = bp_ff + sz_ff;
            sz_in = sz_ff + rdsize;
         end
         OP_M_PREV_HDR_RD: begin
            bp_in = pprev; ub_in = pprev;
            mem_en = 1'b1; mem_addr = pprev - 17'd4;
         end
         OP_M_PREV_MERGE: sz_in = sz_ff + rdsize;
         OP_M_HDR_WR: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff - 17'd4;
            mem_wdata = {15'd0, sz_ff};
         end
         OP_M_FTR_WR: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff + sz_ff - TAG_BYTES;
            mem_wdata = {15'd0, sz_ff};
         end
         OP_PUSH_NEXT: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff + 17'd8;
            mem_wdata = {16'd0, fhead_ff};
         end
         OP_PUSH_BACK: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = {1'b0, fhead_ff};
            mem_wdata = {15'd0, bp_ff};
         end
         OP_PUSH_HEAD: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff; mem_wdata = '0;
            fhead_in = bp_ff[15:0];
         end
         OP_UL_PREV_RD: begin
            mem_en = 1'b1; mem_addr = ub_ff;
         end
         OP_UL_NEXT_RD: begin
            lp_in = rd[15:0];
            mem_en = 1'b1; mem_addr = ub_ff + 17'd8;
         end
         OP_UL_FIX_PREV: begin
            ln_in = rd[15:0];
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = {1'b0, lp_ff} + 17'd8;
            mem_wdata = {16'd0, rd[15:0]};
         end
         OP_UL_FIX_HEAD: begin
            ln_in = rd[15:0];
            fhead_in = rd[15:0];
         end
         OP_UL_FIX_NEXT: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = {1'b0, ln_ff};
            mem_wdata = {16'd0, lp_ff};
         end
         OP_W_START: p_in = FIRST_PAYLD;
         OP_W_RD: begin
            mem_en = 1'b1; mem_addr = p_ff - 17'd4;
         end
         OP_W_STEP: p_in = p_ff + rdsize;
         OP_F_HDR: begin
            bp_in = p_ff; sz_in = rdsize;
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = p_ff - 17'd4;
            mem_wdata = {15'd0, rdsize};
         end
         OP_F_FTR: begin
            mem_en = 1'b1; mem_we = 1'b1; mem_addr = bp_ff + sz_ff - TAG_BYTES;
            mem_wdata = {15'd0, sz_ff};
         end
         OP_OUT: begin
            rsp_valid_in = 1'b1; rsp_status_in = st_ff; rsp_addr_in = grant_ff;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fhead_ff     <= 16'd0;
         hend_ff      <= 17'd0;
         gfail_ff     <= 1'b0;
         chunk_ff     <= CHUNK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fhead_ff     <= fhead_in;
         hend_ff      <= hend_in;
         gfail_ff     <= gfail_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;       size_ff <= size_in;     baddr_ff <= baddr_in;
      st_ff <= st_in;         grant_ff <= grant_in;   asize_ff <= asize_in;
      gbytes_ff <= gbytes_in; fb_ff <= fb_in;         bp_ff <= bp_in;
      sz_ff <= sz_in;         ub_ff <= ub_in;         lp_ff <= lp_in;
      ln_ff <= ln_in;         pws_ff <= pws_in;       pwf_ff <= pwf_in;
      csize_ff <= csize_in;   p_ff <= p_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_payload_addr = rsp_addr_ff;

`ifndef SYNTHESIS
   // heap never grows past its limit
   a_hend_limit: assert property (@(posedge clock) disable iff (reset)
      {2'b00, hend_ff} <= 19'(MEM_LIMIT))
      else $error("heap end past limit");
   // free list head is always block aligned
   a_fhead_align: assert property (@(posedge clock) disable iff (reset)
      fhead_ff[2:0] == 3'd0)
      else $error("free list head misaligned");
   // a granted address only comes with a done status
   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_addr_ff != 16'd0) |-> (rsp_status_ff == ST_DONE))
      else $error("address granted with failure status");
   // a pending response is not overwritten before it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_addr_ff)))
      else $error("response dropped");
`endif
endmodule

// ===== hw/rtl/efl_ctrl.sv =====
module efl_ctrl
   import efl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output op_type        op
);
   state_type state_ff, state_in;
   state_type grow_ret_ff, grow_ret_in;
   state_type merge_ret_ff, merge_ret_in;
   state_type ul_ret_ff, ul_ret_in;

   // next state and return points
   always_comb begin
      state_in     = state_ff;
      grow_ret_in  = grow_ret_ff;
      merge_ret_in = merge_ret_ff;
      ul_ret_in    = ul_ret_ff;
      case (state_ff)
         S_INIT0: state_in = S_INIT1;
         S_INIT1: state_in = S_INIT2;
         S_INIT2: begin
            state_in = S_G_CHK; grow_ret_in = S_IDLE;
         end
         S_IDLE: if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (status.cmd_free) state_in = S_F_START;
            else if (status.req_zero) state_in = S_RESP;
            else state_in = S_A_FIT;
         end
         S_A_FIT: begin
            if (status.fit_null) begin
               state_in = S_G_CHK; grow_ret_in = S_A_GROWN;
            end else begin
               state_in = S_A_FIT_CHK;
            end
         end
         S_A_FIT_CHK: state_in = status.fit_ok ? S_C_RD : S_A_FIT_NEXT;
         S_A_FIT_NEXT: state_in = S_A_FIT;
         S_A_GROWN: state_in = status.gfail ? S_RESP : S_C_RD;
         S_C_RD: state_in = S_C_UL;
         S_C_UL: begin
            state_in = S_U_PREV; ul_ret_in = S_C_DECIDE;
         end
         S_C_DECIDE: state_in = status.split ? S_C_FTR_SPLIT : S_C_FTR_WHOLE;
         S_C_FTR_SPLIT: state_in = S_C_REM_HDR;
         S_C_REM_HDR: state_in = S_C_REM_FTR;
         S_C_REM_FTR: begin
            state_in = S_M_HDR; merge_ret_in = S_RESP;
         end
         S_C_FTR_WHOLE: state_in = S_RESP;
         S_G_CHK: state_in = status.grow_fits ? S_G_FTR : grow_ret_ff;
         S_G_FTR: state_in = S_G_EPI;
         S_G_EPI: begin
            state_in = S_M_HDR; merge_ret_in = grow_ret_ff;
         end
         S_M_HDR: state_in = S_M_PREV;
         S_M_PREV: state_in = S_M_NEXT;
         S_M_NEXT: state_in = S_M_NCHK;
         S_M_NCHK: begin
            if (status.next_free) begin
               state_in = S_U_PREV; ul_ret_in = S_M_PCHK;
            end else begin
               state_in = S_M_PCHK;
            end
         end
         S_M_PCHK: state_in = status.prev_free ? S_M_PMERGE : S_M_HDR_WR;
         S_M_PMERGE: begin
            state_in = S_U_PREV; ul_ret_in = S_M_HDR_WR;
         end
         S_M_HDR_WR: state_in = S_M_FTR_WR;
         S_M_FTR_WR: state_in = S_P_NEXT;
         S_P_NEXT: state_in = S_P_BACK;
         S_P_BACK: state_in = S_P_HEAD;
         S_P_HEAD: state_in = merge_ret_ff;
         S_U_PREV: state_in = S_U_NEXT;
         S_U_NEXT: state_in = S_U_FIX;
         S_U_FIX: state_in = S_U_FIXN;
         S_U_FIXN: state_in = ul_ret_ff;
         S_F_START: state_in = status.addr_zero ? S_RESP : S_F_WALK;
         S_F_WALK: state_in = status.walk_end ? S_RESP : S_F_CHK;
         S_F_CHK: begin
            if (status.walk_size0) state_in = S_RESP;
            else if (status.walk_hit) state_in = status.walk_alloc ? S_F_FTR : S_RESP;
            else if (status.walk_past) state_in = S_RESP;
            else state_in = S_F_WALK;
         end
         S_F_FTR: begin
            state_in = S_M_HDR; merge_ret_in = S_RESP;
         end
         S_RESP: if (status.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // operation per state
   always_comb begin
      op = OP_NONE;
      case (state_ff)
         S_INIT0: op = OP_INIT0;
         S_INIT1: op = OP_INIT1;
         S_INIT2: op = OP_INIT2;
         S_IDLE: if (req_valid) op = OP_LATCH;
         S_DISPATCH: begin
            if (status.cmd_free) op = OP_NONE;
            else if (status.req_zero) op = OP_SET_IGN;
            else op = OP_ASIZE;
         end
         S_A_FIT: op = status.fit_null ? OP_GROW_SETUP : OP_FIT_RD;
         S_A_FIT_CHK: op = status.fit_ok ? OP_FIT_TAKE : OP_FIT_NEXT_RD;
         S_A_FIT_NEXT: op = OP_FIT_NEXT;
         S_A_GROWN: if (status.gfail) op = OP_SET_OOM;
         S_C_RD: op = OP_CARVE_RD;
         S_C_UL: op = OP_CARVE_UL;
         S_C_DECIDE: op = status.split ? OP_CARVE_HDR_SPLIT : OP_CARVE_HDR_WHOLE;
         S_C_FTR_SPLIT: op = OP_CARVE_FTR_SPLIT;
         S_C_REM_HDR: op = OP_CARVE_REM_HDR;
         S_C_REM_FTR: op = OP_CARVE_REM_FTR;
         S_C_FTR_WHOLE: op = OP_CARVE_FTR_WHOLE;
         S_G_CHK: op = status.grow_fits ? OP_GROW_HDR : OP_GROW_FAIL;
         S_G_FTR: op = OP_GROW_FTR;
         S_G_EPI: op = OP_GROW_EPI;
         S_M_HDR: op = OP_M_HDR_RD;
         S_M_PREV: op = OP_M_PREV_RD;
         S_M_NEXT: op = OP_M_NEXT_RD;
         S_M_NCHK: if (status.next_free) op = OP_M_NEXT_MERGE;
         S_M_PCHK: if (status.prev_free) op = OP_M_PREV_HDR_RD;
         S_M_PMERGE: op = OP_M_PREV_MERGE;
         S_M_HDR_WR: op = OP_M_HDR_WR;
         S_M_FTR_WR: op = OP_M_FTR_WR;
         S_P_NEXT: op = OP_PUSH_NEXT;
         S_P_BACK: if (status.fhead_nz) op = OP_PUSH_BACK;
         S_P_HEAD: op = OP_PUSH_HEAD;
         S_U_PREV: op = OP_UL_PREV_RD;
         S_U_NEXT: op = OP_UL_NEXT_RD;
         S_U_FIX: op = status.lp_nz ? OP_UL_FIX_PREV : OP_UL_FIX_HEAD;
         S_U_FIXN: if (status.ln_nz) op = OP_UL_FIX_NEXT;
         S_F_START: op = status.addr_zero ? OP_SET_IGN : OP_W_START;
         S_F_WALK: op = status.walk_end ? OP_SET_IGN : OP_W_RD;
         S_F_CHK: begin
            if (status.walk_size0) op = OP_SET_IGN;
            else if (status.walk_hit) op = status.walk_alloc ? OP_F_HDR : OP_SET_IGN;
            else if (status.walk_past) op = OP_SET_IGN;
            else op = OP_W_STEP;
         end
         S_F_FTR: op = OP_F_FTR;
         S_RESP: if (status.out_free) op = OP_OUT;
         default: op = OP_NONE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT0;
         grow_ret_ff  <= S_IDLE;
         merge_ret_ff <= S_IDLE;
         ul_ret_ff    <= S_IDLE;
      end else begin
         state_ff     <= state_in;
         grow_ret_ff  <= grow_ret_in;
         merge_ret_ff <= merge_ret_in;
         ul_ret_ff    <= ul_ret_in;
      end
   end

`ifndef SYNTHESIS
   // a request is only taken after start-up is over
   a_no_req_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT0 || state_ff == S_INIT1 || state_ff == S_INIT2) |-> !req_ready)
      else $error("request accepted during start-up");
   // an accepted request always moves to dispatch
   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted request not dispatched");
   // the response state only leaves when the output register is free
   a_resp_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !status.out_free) |=> (state_ff == S_RESP))
      else $error("response lost");
`endif
endmodule
